/* hw/rtl/lcabl_pkg.sv */
// Shared constants, types, address helpers and the microprogram of the LCA unit.
`timescale 1ns / 1ps

package lcabl_pkg;

    localparam int NODE_W      = 10;
    localparam int DEPTH_W     = 10;
    localparam int MAX_NODES   = 1024;
    localparam int JUMP_LEVELS = 10;
    localparam int SLOT_W      = $clog2(MAX_NODES);
    localparam int K_W         = $clog2(JUMP_LEVELS + 1);
    localparam int ANC_W       = NODE_W + 1;
    localparam int ANC_DEPTH   = MAX_NODES * JUMP_LEVELS;
    localparam int ANC_AW      = $clog2(ANC_DEPTH);
    localparam int IN_DATA_W   = 24;
    localparam int IN_USER_W   = 2;
    localparam int OUT_DATA_W  = 24;
    localparam int PC_W        = 5;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};
    localparam logic [ANC_W-1:0]   NO_ANC    = {1'b1, {NODE_W{1'b0}}};

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_WR_NOANC,
        OP_EMIT_ADD,
        OP_RD_DEP_B,
        OP_ADD_FIRST,
        OP_RD_ANC_PREV,
        OP_WR_LEVEL,
        OP_RD_DEP_A,
        OP_CAP_DA,
        OP_ORDER,
        OP_RD_ANC_A_K,
        OP_LIFT,
        OP_SET_K_TOP,
        OP_RD_ANC_A_KM1,
        OP_CAP_NA,
        OP_JOINT,
        OP_TAKE_P,
        OP_EMIT_Q,
        OP_EMIT_ZERO
    } t_op;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_QUERY,
        C_NOT_ROOT,
        C_K_NOT_LAST,
        C_K_END,
        C_K_ZERO,
        C_A_EQ_B,
        C_P_NONE
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            wait_out;
    } t_uword;

    typedef struct packed {
        logic in_fire;
        logic query;
        logic not_root;
        logic k_last;
        logic k_end;
        logic k_zero;
        logic a_eq_b;
        logic p_none;
        logic out_stall;
    } t_flags;

    localparam logic [PC_W-1:0] S_LOAD      = 5'd0;
    localparam logic [PC_W-1:0] S_DISP      = 5'd1;
    localparam logic [PC_W-1:0] S_KIND      = 5'd2;
    localparam logic [PC_W-1:0] S_ROOT      = 5'd3;
    localparam logic [PC_W-1:0] S_EMIT_ADD  = 5'd4;
    localparam logic [PC_W-1:0] S_ADD_DEP   = 5'd5;
    localparam logic [PC_W-1:0] S_ADD_FIRST = 5'd6;
    localparam logic [PC_W-1:0] S_ADD_RD    = 5'd7;
    localparam logic [PC_W-1:0] S_ADD_WR    = 5'd8;
    localparam logic [PC_W-1:0] S_Q_DA      = 5'd9;
    localparam logic [PC_W-1:0] S_Q_DB      = 5'd10;
    localparam logic [PC_W-1:0] S_Q_ORDER   = 5'd11;
    localparam logic [PC_W-1:0] S_LIFT_RD   = 5'd12;
    localparam logic [PC_W-1:0] S_LIFT      = 5'd13;
    localparam logic [PC_W-1:0] S_TOP       = 5'd14;
    localparam logic [PC_W-1:0] S_JOINT_RA  = 5'd15;
    localparam logic [PC_W-1:0] S_JOINT_RB  = 5'd16;
    localparam logic [PC_W-1:0] S_JOINT     = 5'd17;
    localparam logic [PC_W-1:0] S_PARENT    = 5'd18;
    localparam logic [PC_W-1:0] S_ANS_DEP   = 5'd19;
    localparam logic [PC_W-1:0] S_EMIT_Q    = 5'd20;
    localparam logic [PC_W-1:0] S_EMIT_ZERO = 5'd21;

    function automatic t_uword mk(input t_op op, input t_cond cond,
                                  input logic [PC_W-1:0] target, input logic wait_out);
        t_uword w;
        w.op       = op;
        w.cond     = cond;
        w.target   = target;
        w.wait_out = wait_out;
        return w;
    endfunction

    // A step jumps to its target when its condition holds and falls through otherwise.
    function automatic t_uword prog_word(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            S_LOAD:      w = mk(OP_LOAD,         C_NO_IN,      S_LOAD,      1'b0);
            S_DISP:      w = mk(OP_NOP,          C_QUERY,      S_Q_DA,      1'b0);
            S_KIND:      w = mk(OP_NOP,          C_NOT_ROOT,   S_ADD_DEP,   1'b0);
            S_ROOT:      w = mk(OP_WR_NOANC,     C_K_NOT_LAST, S_ROOT,      1'b0);
            S_EMIT_ADD:  w = mk(OP_EMIT_ADD,     C_ALWAYS,     S_LOAD,      1'b1);
            S_ADD_DEP:   w = mk(OP_RD_DEP_B,     C_NEVER,      S_LOAD,      1'b0);
            S_ADD_FIRST: w = mk(OP_ADD_FIRST,    C_NEVER,      S_LOAD,      1'b0);
            S_ADD_RD:    w = mk(OP_RD_ANC_PREV,  C_K_END,      S_EMIT_ADD,  1'b0);
            S_ADD_WR:    w = mk(OP_WR_LEVEL,     C_ALWAYS,     S_ADD_RD,    1'b0);
            S_Q_DA:      w = mk(OP_RD_DEP_A,     C_NEVER,      S_LOAD,      1'b0);
            S_Q_DB:      w = mk(OP_CAP_DA,       C_NEVER,      S_LOAD,      1'b0);
            S_Q_ORDER:   w = mk(OP_ORDER,        C_NEVER,      S_LOAD,      1'b0);
            S_LIFT_RD:   w = mk(OP_RD_ANC_A_K,   C_K_END,      S_TOP,       1'b0);
            S_LIFT:      w = mk(OP_LIFT,         C_ALWAYS,     S_LIFT_RD,   1'b0);
            S_TOP:       w = mk(OP_SET_K_TOP,    C_A_EQ_B,     S_ANS_DEP,   1'b0);
            S_JOINT_RA:  w = mk(OP_RD_ANC_A_KM1, C_K_ZERO,     S_PARENT,    1'b0);
            S_JOINT_RB:  w = mk(OP_CAP_NA,       C_NEVER,      S_LOAD,      1'b0);
            S_JOINT:     w = mk(OP_JOINT,        C_ALWAYS,     S_JOINT_RA,  1'b0);
            S_PARENT:    w = mk(OP_TAKE_P,       C_P_NONE,     S_EMIT_ZERO, 1'b0);
            S_ANS_DEP:   w = mk(OP_RD_DEP_A,     C_NEVER,      S_LOAD,      1'b0);
            S_EMIT_Q:    w = mk(OP_EMIT_Q,       C_ALWAYS,     S_LOAD,      1'b1);
            S_EMIT_ZERO: w = mk(OP_EMIT_ZERO,    C_ALWAYS,     S_LOAD,      1'b1);
            default:     w = mk(OP_NOP,          C_ALWAYS,     S_LOAD,      1'b0);
        endcase
        return w;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node);
        return SLOT_W'(node % MAX_NODES);
    endfunction

    // Levels outside the row fall back to level zero so the address stays in range.
    function automatic logic [ANC_AW-1:0] anc_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [K_W-1:0] lvl);
        logic [K_W-1:0] l;
        l = (lvl < K_W'(JUMP_LEVELS)) ? lvl : '0;
        return ANC_AW'(s) * ANC_AW'(JUMP_LEVELS) + ANC_AW'(l);
    endfunction

endpackage

/* hw/rtl/lcabl_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module lcabl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/lcabl_useq.sv */
// Microprogram sequencer: step counter, control store lookup and conditional jumps.
`timescale 1ns / 1ps

module lcabl_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcabl_pkg::t_flags   i_flags,
    output lcabl_pkg::t_uword   o_uword
);

    logic [lcabl_pkg::PC_W-1:0] r_pc;
    logic [lcabl_pkg::PC_W-1:0] n_pc;
    lcabl_pkg::t_uword          w_uw;
    logic                       w_take;

    assign w_uw = lcabl_pkg::prog_word(r_pc);

    always_comb begin
        case (w_uw.cond)
            lcabl_pkg::C_NEVER:      w_take = 1'b0;
            lcabl_pkg::C_ALWAYS:     w_take = 1'b1;
            lcabl_pkg::C_NO_IN:      w_take = !i_flags.in_fire;
            lcabl_pkg::C_QUERY:      w_take = i_flags.query;
            lcabl_pkg::C_NOT_ROOT:   w_take = i_flags.not_root;
            lcabl_pkg::C_K_NOT_LAST: w_take = !i_flags.k_last;
            lcabl_pkg::C_K_END:      w_take = i_flags.k_end;
            lcabl_pkg::C_K_ZERO:     w_take = i_flags.k_zero;
            lcabl_pkg::C_A_EQ_B:     w_take = i_flags.a_eq_b;
            lcabl_pkg::C_P_NONE:     w_take = i_flags.p_none;
            default:                 w_take = 1'b0;
        endcase
    end

    always_comb begin
        if (w_uw.wait_out && i_flags.out_stall) begin
            n_pc = r_pc;
        end else if (w_take) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= lcabl_pkg::S_LOAD;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uword = w_uw;

endmodule

/* hw/rtl/lcabl_datapath.sv */
// Datapath: node registers, level counter, both tables and the output register.
`timescale 1ns / 1ps

module lcabl_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lcabl_pkg::t_uword                   i_uword,
    output lcabl_pkg::t_flags                   o_flags,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_in_command,
    input  logic [lcabl_pkg::NODE_W-1:0]        i_in_first,
    input  logic [lcabl_pkg::NODE_W-1:0]        i_in_second,
    input  logic                                i_in_root,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [lcabl_pkg::NODE_W-1:0]        o_out_node,
    output logic [lcabl_pkg::DEPTH_W-1:0]       o_out_depth
);

    logic                            r_cmd;
    logic                            r_root;
    logic [lcabl_pkg::NODE_W-1:0]    r_a;
    logic [lcabl_pkg::NODE_W-1:0]    r_b;
    logic [lcabl_pkg::K_W-1:0]       r_k;
    logic [lcabl_pkg::DEPTH_W-1:0]   r_d;
    logic [lcabl_pkg::DEPTH_W-1:0]   r_da;
    logic [lcabl_pkg::DEPTH_W-1:0]   r_diff;
    logic [lcabl_pkg::ANC_W-1:0]     r_prev;
    logic [lcabl_pkg::ANC_W-1:0]     r_na;
    logic                            r_out_valid;
    logic [lcabl_pkg::NODE_W-1:0]    r_out_node;
    logic [lcabl_pkg::DEPTH_W-1:0]   r_out_depth;

    logic [lcabl_pkg::K_W-1:0]       w_km1;
    logic                            w_fire;
    logic                            w_stall;
    logic [lcabl_pkg::ANC_W-1:0]     w_level_val;

    logic                            w_dep_we;
    logic [lcabl_pkg::SLOT_W-1:0]    w_dep_raddr;
    logic [lcabl_pkg::DEPTH_W-1:0]   w_dep_q;
    logic                            w_anc_we;
    logic [lcabl_pkg::ANC_AW-1:0]    w_anc_waddr;
    logic [lcabl_pkg::ANC_W-1:0]     w_anc_wdata;
    logic [lcabl_pkg::ANC_AW-1:0]    w_anc_raddr;
    logic [lcabl_pkg::ANC_W-1:0]     w_anc_q;

    assign w_km1       = r_k - 1'b1;
    assign o_in_ready  = (i_uword.op == lcabl_pkg::OP_LOAD);
    assign w_fire      = i_in_valid && o_in_ready;
    assign w_stall     = r_out_valid && !i_out_ready;
    assign w_level_val = r_prev[lcabl_pkg::NODE_W] ? lcabl_pkg::NO_ANC : w_anc_q;

    always_comb begin
        case (i_uword.op)
            lcabl_pkg::OP_RD_DEP_B, lcabl_pkg::OP_CAP_DA: w_dep_raddr = lcabl_pkg::slot_of(r_b);
            default:                                      w_dep_raddr = lcabl_pkg::slot_of(r_a);
        endcase
    end

    always_comb begin
        case (i_uword.op)
            lcabl_pkg::OP_RD_ANC_PREV:
                w_anc_raddr = lcabl_pkg::anc_addr(
                    lcabl_pkg::slot_of(r_prev[lcabl_pkg::NODE_W-1:0]), w_km1);
            lcabl_pkg::OP_RD_ANC_A_KM1:
                w_anc_raddr = lcabl_pkg::anc_addr(lcabl_pkg::slot_of(r_a), w_km1);
            lcabl_pkg::OP_CAP_NA:
                w_anc_raddr = lcabl_pkg::anc_addr(lcabl_pkg::slot_of(r_b), w_km1);
            default:
                w_anc_raddr = lcabl_pkg::anc_addr(lcabl_pkg::slot_of(r_a), r_k);
        endcase
    end

    always_comb begin
        w_anc_we    = 1'b0;
        w_anc_waddr = lcabl_pkg::anc_addr(lcabl_pkg::slot_of(r_a), r_k);
        w_anc_wdata = lcabl_pkg::NO_ANC;
        case (i_uword.op)
            lcabl_pkg::OP_WR_NOANC: begin
                w_anc_we = 1'b1;
            end
            lcabl_pkg::OP_ADD_FIRST: begin
                w_anc_we    = 1'b1;
                w_anc_waddr = lcabl_pkg::anc_addr(lcabl_pkg::slot_of(r_a), '0);
                w_anc_wdata = {1'b0, r_b};
            end
            lcabl_pkg::OP_WR_LEVEL: begin
                w_anc_we    = 1'b1;
                w_anc_wdata = w_level_val;
            end
            default: begin
                w_anc_we = 1'b0;
            end
        endcase
    end

    assign w_dep_we = (i_uword.op == lcabl_pkg::OP_EMIT_ADD) && !w_stall;

    lcabl_ram #(
        .WIDTH (lcabl_pkg::DEPTH_W),
        .DEPTH (lcabl_pkg::MAX_NODES)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (w_dep_we),
        .i_waddr (lcabl_pkg::slot_of(r_a)),
        .i_wdata (r_d),
        .i_raddr (w_dep_raddr),
        .o_rdata (w_dep_q)
    );

    lcabl_ram #(
        .WIDTH (lcabl_pkg::ANC_W),
        .DEPTH (lcabl_pkg::ANC_DEPTH)
    ) u_anc_ram (
        .i_clk   (i_clk),
        .i_we    (w_anc_we),
        .i_waddr (w_anc_waddr),
        .i_wdata (w_anc_wdata),
        .i_raddr (w_anc_raddr),
        .o_rdata (w_anc_q)
    );

    always_ff @(posedge i_clk) begin
        case (i_uword.op)
            lcabl_pkg::OP_LOAD: begin
                if (w_fire) begin
                    r_cmd  <= i_in_command;
                    r_root <= i_in_root;
                    r_a    <= i_in_first;
                    r_b    <= i_in_second;
                    r_k    <= '0;
                    r_d    <= '0;
                end
            end
            lcabl_pkg::OP_WR_NOANC: begin
                r_k <= r_k + 1'b1;
            end
            lcabl_pkg::OP_ADD_FIRST: begin
                r_d    <= (w_dep_q == lcabl_pkg::DEPTH_MAX) ? lcabl_pkg::DEPTH_MAX
                                                            : w_dep_q + 1'b1;
                r_prev <= {1'b0, r_b};
                r_k    <= lcabl_pkg::K_W'(1);
            end
            lcabl_pkg::OP_WR_LEVEL: begin
                r_prev <= w_level_val;
                r_k    <= r_k + 1'b1;
            end
            lcabl_pkg::OP_CAP_DA: begin
                r_da <= w_dep_q;
            end
            lcabl_pkg::OP_ORDER: begin
                r_k <= '0;
                if (r_da < w_dep_q) begin
                    r_a    <= r_b;
                    r_b    <= r_a;
                    r_diff <= w_dep_q - r_da;
                end else begin
                    r_diff <= r_da - w_dep_q;
                end
            end
            lcabl_pkg::OP_LIFT: begin
                if (r_diff[r_k] && !w_anc_q[lcabl_pkg::NODE_W]) begin
                    r_a <= w_anc_q[lcabl_pkg::NODE_W-1:0];
                end
                r_k <= r_k + 1'b1;
            end
            lcabl_pkg::OP_SET_K_TOP: begin
                r_k <= lcabl_pkg::K_W'(lcabl_pkg::JUMP_LEVELS);
            end
            lcabl_pkg::OP_CAP_NA: begin
                r_na <= w_anc_q;
            end
            lcabl_pkg::OP_JOINT: begin
                if (r_na != w_anc_q && !r_na[lcabl_pkg::NODE_W]
                        && !w_anc_q[lcabl_pkg::NODE_W]) begin
                    r_a <= r_na[lcabl_pkg::NODE_W-1:0];
                    r_b <= w_anc_q[lcabl_pkg::NODE_W-1:0];
                end
                r_k <= w_km1;
            end
            lcabl_pkg::OP_TAKE_P: begin
                if (!w_anc_q[lcabl_pkg::NODE_W]) begin
                    r_a <= w_anc_q[lcabl_pkg::NODE_W-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_uword.wait_out && !w_stall) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall) begin
            case (i_uword.op)
                lcabl_pkg::OP_EMIT_ADD: begin
                    r_out_node  <= r_a;
                    r_out_depth <= r_d;
                end
                lcabl_pkg::OP_EMIT_Q: begin
                    r_out_node  <= r_a;
                    r_out_depth <= w_dep_q;
                end
                lcabl_pkg::OP_EMIT_ZERO: begin
                    r_out_node  <= '0;
                    r_out_depth <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_flags.in_fire   = w_fire;
    assign o_flags.query     = r_cmd;
    assign o_flags.not_root  = !r_root;
    assign o_flags.k_last    = (r_k == lcabl_pkg::K_W'(lcabl_pkg::JUMP_LEVELS - 1));
    assign o_flags.k_end     = (r_k == lcabl_pkg::K_W'(lcabl_pkg::JUMP_LEVELS));
    assign o_flags.k_zero    = (r_k == '0);
    assign o_flags.a_eq_b    = (r_a == r_b);
    assign o_flags.p_none    = w_anc_q[lcabl_pkg::NODE_W];
    assign o_flags.out_stall = w_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_node  = r_out_node;
    assign o_out_depth = r_out_depth;

endmodule

/* hw/rtl/lca_binary_lifting_unit.sv */
// Top level of the lowest common ancestor unit: sequencer, datapath and stream ports.
// One word at a time. A root add writes a no-ancestor entry at each level of its row; a child
// add reads and writes each level in turn through the single read port of the table. A query
// reads both depths, equalizes them with a read and a lift step per level, then lifts both nodes
// with two reads and a joint step per level. A result is valid the cycle after its emit step.
// Synchronous active-low reset clears the step counter and the output valid, not the tables.
`timescale 1ns / 1ps

module lca_binary_lifting_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // first_node [9:0], second_node [19:10], zero [23:20]
    input  logic [lcabl_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // command [0], is_root [1]
    input  logic [lcabl_pkg::IN_USER_W-1:0]     i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // answer_node [9:0], answer_depth [19:10], zero [23:20]
    output logic [lcabl_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata
);

    lcabl_pkg::t_uword                  w_uword;
    lcabl_pkg::t_flags                  w_flags;
    logic [lcabl_pkg::NODE_W-1:0]       w_out_node;
    logic [lcabl_pkg::DEPTH_W-1:0]      w_out_depth;

    lcabl_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_uword (w_uword)
    );

    lcabl_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_uword      (w_uword),
        .o_flags      (w_flags),
        .i_in_valid   (i_s_axis_tvalid),
        .o_in_ready   (o_s_axis_tready),
        .i_in_command (i_s_axis_tuser[0]),
        .i_in_first   (i_s_axis_tdata[9:0]),
        .i_in_second  (i_s_axis_tdata[19:10]),
        .i_in_root    (i_s_axis_tuser[1]),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_out_node   (w_out_node),
        .o_out_depth  (w_out_depth)
    );

    assign o_m_axis_tdata = {4'b0000, w_out_depth, w_out_node};

`ifndef NO_ASSERTIONS
    a_one_word_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input accepted twice in a row");

    a_emit_holds_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_uword.wait_out && w_flags.out_stall |=> $stable(w_uword))
        else $error("sequencer left an emit step while the output was stalled");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("unit not idle after reset");
`endif

endmodule
